// ===== sv/lfme_pkg.sv =====
// ----------------------------------------------------------------------------
// lfme_pkg
// Shared types and constants of the label filter match engine: command codes,
// register indexes, sequencer states and the match unit control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lfme_pkg;

    // label and query geometry
    localparam int LABEL_W      = 32;
    localparam int QUERY_FIELDS = 4;
    localparam int QUERY_LABELS = 4;
    localparam int QC_LIMIT     = (QUERY_LABELS < QUERY_FIELDS) ? QUERY_LABELS : QUERY_FIELDS;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SWAP   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic {
        REG_UNIVERSAL_ENABLE = 1'b0,
        REG_UNIVERSAL_VALUE  = 1'b1
    } reg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_GOT_A,
        ST_GOT_B,
        ST_SWAP_W,
        ST_SCAN,
        ST_EVAL,
        ST_DONE
    } state_t;

    // match unit control
    typedef struct packed {
        logic clear;
        logic step;
    } match_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lfme_ram.sv =====
// ----------------------------------------------------------------------------
// lfme_ram
// Simple dual-port RAM: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfme_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/lfme_match.sv =====
// ----------------------------------------------------------------------------
// lfme_match
// Shared compare unit: each step compares one stored label against the query
// labels enabled by qmask and the universal label and accumulates the hits.
// ----------------------------------------------------------------------------
`default_nettype none

module lfme_match
    import lfme_pkg::*;
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire match_ctl_t                            ctl,
    input  wire logic [LABEL_W-1:0]                    label,
    input  wire logic [QUERY_FIELDS-1:0][LABEL_W-1:0]  qlabels,
    input  wire logic [QUERY_FIELDS-1:0]               qmask,
    input  wire logic                                  search,
    input  wire logic                                  uni_en,
    input  wire logic [LABEL_W-1:0]                    uni_val,
    output logic                                       matched
);

    logic                    hit_q_reg, hit_q_next;
    logic                    hit_u_reg, hit_u_next;
    logic [QUERY_FIELDS-1:0] eq_q;
    logic [QUERY_FIELDS-1:0] q_is_uni;

    // per-lane compares
    always_comb
    begin
        for (int i = 0; i < QUERY_FIELDS; i++)
        begin
            eq_q[i]     = qmask[i] && (label == qlabels[i]);
            q_is_uni[i] = qmask[i] && (qlabels[i] == uni_val);
        end
    end

    // hit accumulation
    always_comb
    begin
        hit_q_next = hit_q_reg;
        hit_u_next = hit_u_reg;
        if (ctl.clear)
        begin
            hit_q_next = 1'b0;
            hit_u_next = 1'b0;
        end
        else if (ctl.step)
        begin
            hit_q_next = hit_q_reg | (|eq_q);
            hit_u_next = hit_u_reg | (label == uni_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_q_reg <= 1'b0;
            hit_u_reg <= 1'b0;
        end
        else
        begin
            hit_q_reg <= hit_q_next;
            hit_u_reg <= hit_u_next;
        end
    end

    // common label first, universal rule as fallback
    assign matched = hit_q_reg | (uni_en & (hit_u_reg | (~search & (|q_is_uni))));

endmodule

`default_nettype wire

// ===== sv/label_filter_match_engine_core.sv =====
// ----------------------------------------------------------------------------
// label_filter_match_engine_core
// Per-point label lists with clear, append, swap and query commands. Points
// map to label slots through an indirection table so a swap only exchanges
// two table words; queries walk the stored labels through one compare unit.
// ----------------------------------------------------------------------------
// sequence: GOT_A, then DONE for clear/append, GOT_B and SWAP_W for swap,
//   SCAN and EVAL for query; out-of-range point straight to DONE; result
//   held in an output register; one transaction at a time, limited by the
//   one-read-per-cycle label memory walk and the single map port
// reset: config registers clear to 0; a clearing pass then empties every
//   list and sets the identity point map, input not ready
`default_nettype none

module label_filter_match_engine_core
    import lfme_pkg::*;
#(
    parameter int POINT_COUNT = 1024,
    parameter int MAX_LABELS  = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // point_a, point_b, new_label, query_count,
    // query_label_0, query_label_1, query_label_2, query_label_3
    input  wire logic [183:0] s_axis_tdata,
    // cmd, search_mode
    input  wire logic [2:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // matched, status
    output logic [7:0]        m_axis_tdata,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    localparam int PT_W  = $clog2(POINT_COUNT);
    localparam int CNT_W = $clog2(MAX_LABELS + 1);
    localparam int IDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int SA_W  = $clog2(POINT_COUNT * MAX_LABELS);
    localparam int MW_W  = PT_W + CNT_W;
    localparam logic [31:0]      POINT_COUNT_U = 32'(POINT_COUNT);
    localparam logic [CNT_W-1:0] MAX_CNT       = CNT_W'(MAX_LABELS);
    localparam logic [SA_W-1:0]  ROW_STRIDE    = SA_W'(MAX_LABELS);
    localparam logic [PT_W-1:0]  LAST_POINT    = PT_W'(POINT_COUNT - 1);

    // input field unpacking
    logic [9:0]                             in_point_a;
    logic [9:0]                             in_point_b;
    logic [LABEL_W-1:0]                     in_new_label;
    logic [2:0]                             in_query_count;
    logic [QUERY_FIELDS-1:0][LABEL_W-1:0]   in_qlabels;
    cmd_t                                   in_cmd;
    logic                                   in_search;

    assign in_point_a     = s_axis_tdata[9:0];
    assign in_point_b     = s_axis_tdata[19:10];
    assign in_new_label   = s_axis_tdata[51:20];
    assign in_query_count = s_axis_tdata[54:52];
    assign in_qlabels[0]  = s_axis_tdata[86:55];
    assign in_qlabels[1]  = s_axis_tdata[118:87];
    assign in_qlabels[2]  = s_axis_tdata[150:119];
    assign in_qlabels[3]  = s_axis_tdata[182:151];
    assign in_cmd         = cmd_t'(s_axis_tuser[1:0]);
    assign in_search      = s_axis_tuser[2];

    // control registers
    state_t                   state_reg, state_next;
    logic [PT_W-1:0]          init_cnt_reg, init_cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     uni_en_reg;
    logic [LABEL_W-1:0]       uni_val_reg;

    // payload registers
    cmd_t                                 cmd_reg, cmd_next;
    logic [PT_W-1:0]                      pa_reg, pa_next;
    logic [PT_W-1:0]                      pb_reg, pb_next;
    logic [LABEL_W-1:0]                   nl_reg, nl_next;
    logic [QUERY_FIELDS-1:0][LABEL_W-1:0] qlab_reg, qlab_next;
    logic [QUERY_FIELDS-1:0]              qmask_reg, qmask_next;
    logic                                 search_reg, search_next;
    logic [PT_W-1:0]                      slot_reg, slot_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic                                 res_matched_reg, res_matched_next;
    logic                                 res_status_reg, res_status_next;
    logic                                 out_matched_reg, out_matched_next;
    logic                                 out_status_reg, out_status_next;

    // memory ports
    logic               map_we;
    logic [PT_W-1:0]    map_waddr;
    logic [MW_W-1:0]    map_wdata;
    logic [PT_W-1:0]    map_raddr;
    logic [MW_W-1:0]    map_rdata;
    logic [PT_W-1:0]    map_rd_slot;
    logic [CNT_W-1:0]   map_rd_cnt;
    logic               lab_we;
    logic [SA_W-1:0]    lab_waddr;
    logic [SA_W-1:0]    lab_raddr;
    logic [LABEL_W-1:0] lab_rdata;

    // match unit
    match_ctl_t         mctl;
    logic               matched;

    // decode helpers
    logic                    accept;
    logic                    pa_ok;
    logic                    pb_ok;
    logic [2:0]              qc_eff;
    logic [PT_W-1:0]         row_slot;
    logic [IDX_W-1:0]        rd_idx;
    logic [CNT_W-1:0]        idx_inc;

    assign accept         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready  = (state_reg == ST_IDLE);
    assign pa_ok          = (32'(in_point_a) < POINT_COUNT_U);
    assign pb_ok          = (32'(in_point_b) < POINT_COUNT_U);
    assign qc_eff         = (in_query_count > 3'(QC_LIMIT)) ? 3'(QC_LIMIT) : in_query_count;
    assign map_rd_slot    = map_rdata[MW_W-1:CNT_W];
    assign map_rd_cnt     = map_rdata[CNT_W-1:0];
    assign idx_inc        = CNT_W'(idx_reg) + CNT_W'(1);

    // label memory read address: first entry on map lookup, next entry while scanning
    assign row_slot  = (state_reg == ST_GOT_A) ? map_rd_slot : slot_reg;
    assign rd_idx    = (state_reg == ST_GOT_A) ? IDX_W'(0) : IDX_W'(idx_inc);
    assign lab_raddr = SA_W'(row_slot) * ROW_STRIDE + SA_W'(rd_idx);
    assign lab_waddr = SA_W'(map_rd_slot) * ROW_STRIDE + SA_W'(map_rd_cnt);

    // map read address: point_a at accept, point_b during a swap
    assign map_raddr = (state_reg == ST_IDLE) ? PT_W'(in_point_a) : pb_reg;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg;
        cmd_next         = cmd_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        nl_next          = nl_reg;
        qlab_next        = qlab_reg;
        qmask_next       = qmask_reg;
        search_next      = search_reg;
        slot_next        = slot_reg;
        cnt_next         = cnt_reg;
        res_matched_next = res_matched_reg;
        res_status_next  = res_status_reg;
        out_matched_next = out_matched_reg;
        out_status_next  = out_status_reg;
        map_we           = 1'b0;
        map_waddr        = pa_reg;
        map_wdata        = {map_rd_slot, CNT_W'(0)};
        lab_we           = 1'b0;
        mctl             = '{clear: 1'b0, step: 1'b0};

        // result register drains independently
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                map_we        = 1'b1;
                map_waddr     = init_cnt_reg;
                map_wdata     = {init_cnt_reg, CNT_W'(0)};
                init_cnt_next = init_cnt_reg + PT_W'(1);
                if (init_cnt_reg == LAST_POINT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = in_cmd;
                    pa_next          = PT_W'(in_point_a);
                    pb_next          = PT_W'(in_point_b);
                    nl_next          = in_new_label;
                    qlab_next        = in_qlabels;
                    search_next      = in_search;
                    res_matched_next = 1'b0;
                    res_status_next  = 1'b0;
                    mctl.clear       = 1'b1;
                    for (int i = 0; i < QUERY_FIELDS; i++)
                    begin
                        qmask_next[i] = (3'(i) < qc_eff);
                    end
                    if (!pa_ok || (in_cmd == CMD_SWAP &&
                                   (!pb_ok || in_point_b == in_point_a)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_GOT_A;
                    end
                end
            end
            ST_GOT_A:
            begin
                slot_next = map_rd_slot;
                cnt_next  = map_rd_cnt;
                idx_next  = IDX_W'(0);
                unique case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        map_we     = 1'b1;
                        map_wdata  = {map_rd_slot, CNT_W'(0)};
                        state_next = ST_DONE;
                    end
                    CMD_APPEND:
                    begin
                        if (map_rd_cnt >= MAX_CNT)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            lab_we    = 1'b1;
                            map_we    = 1'b1;
                            map_wdata = {map_rd_slot, map_rd_cnt + CNT_W'(1)};
                        end
                        state_next = ST_DONE;
                    end
                    CMD_SWAP:
                    begin
                        state_next = ST_GOT_B;
                    end
                    CMD_QUERY:
                    begin
                        state_next = (map_rd_cnt == CNT_W'(0)) ? ST_EVAL : ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_GOT_B:
            begin
                // point_a takes point_b's map word
                map_we     = 1'b1;
                map_waddr  = pa_reg;
                map_wdata  = map_rdata;
                state_next = ST_SWAP_W;
            end
            ST_SWAP_W:
            begin
                map_we     = 1'b1;
                map_waddr  = pb_reg;
                map_wdata  = {slot_reg, cnt_reg};
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                mctl.step = 1'b1;
                if (idx_inc < cnt_reg)
                begin
                    idx_next = IDX_W'(idx_inc);
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                res_matched_next = matched;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_matched_next = res_matched_reg;
                    out_status_next  = res_status_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uni_en_reg  <= 1'b0;
            uni_val_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_UNIVERSAL_ENABLE: uni_en_reg  <= cfg_wdata[0];
                REG_UNIVERSAL_VALUE:  uni_val_reg <= cfg_wdata;
                default:              uni_en_reg  <= uni_en_reg;
            endcase
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pa_reg          <= pa_next;
        pb_reg          <= pb_next;
        nl_reg          <= nl_next;
        qlab_reg        <= qlab_next;
        qmask_reg       <= qmask_next;
        search_reg      <= search_next;
        slot_reg        <= slot_next;
        cnt_reg         <= cnt_next;
        res_matched_reg <= res_matched_next;
        res_status_reg  <= res_status_next;
        out_matched_reg <= out_matched_next;
        out_status_reg  <= out_status_next;
    end

    // point map: slot index and list length per point
    lfme_ram #(
        .DEPTH (POINT_COUNT),
        .WIDTH (MW_W)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // label store, one row of MAX_LABELS entries per slot
    lfme_ram #(
        .DEPTH (POINT_COUNT * MAX_LABELS),
        .WIDTH (LABEL_W)
    ) u_labels (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (nl_reg),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    // shared compare unit
    lfme_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mctl),
        .label   (lab_rdata),
        .qlabels (qlab_reg),
        .qmask   (qmask_reg),
        .search  (search_reg),
        .uni_en  (uni_en_reg),
        .uni_val (uni_val_reg),
        .matched (matched)
    );

    // result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_status_reg, out_matched_reg};

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input accepted while a transaction is in flight");

    // scan never reads past the list length
    a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (CNT_W'(idx_reg) < cnt_reg))
        else $error("label scan past list length");

    // stored list length stays within capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GOT_A |-> (map_rd_cnt <= MAX_CNT))
        else $error("list length above capacity");

    // full-list status only from an append
    a_status_append: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_status_reg) |-> (cmd_reg == CMD_APPEND))
        else $error("status raised by a non-append command");

    // a waiting result is not overwritten
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg &&
            $stable(out_matched_reg) && $stable(out_status_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== bench/label_filter_match_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// label_filter_match_engine_core_test
// Self-checking bench for the label filter match engine. A short directed
// table is followed by random command streams over several universal label
// settings. The bench predicts each result from its own copy of the point
// lists and compares every result transaction in order. Both stream sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module label_filter_match_engine_core_test
    import lfme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINT_COUNT  = 1024;
    localparam int MAX_LABELS   = 8;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 260;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // one command as carried by tdata and tuser
    typedef struct packed {
        cmd_t             cmd;
        logic [9:0]       pa;
        logic [9:0]       pb;
        logic [31:0]      lbl;
        logic [2:0]       qcount;
        logic [3:0][31:0] ql;
        logic             search;
    } command_t;

    // one result transaction
    typedef struct packed {
        logic status;
        logic matched;
    } outcome_t;

    typedef struct {
        command_t c;
        bit       known;
        outcome_t want;
    } plan_row_t;

    localparam outcome_t RES_CLEAN   = '{status: 1'b0, matched: 1'b0};
    localparam outcome_t RES_DROPPED = '{status: 1'b1, matched: 1'b0};

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         cfg_we;
    reg_idx_t     cfg_index;
    logic [31:0]  cfg_wdata;

    // predicted block state
    logic [31:0] point_labels [POINT_COUNT][MAX_LABELS];
    int          point_len [POINT_COUNT];
    bit          univ_on;
    logic [31:0] univ_val;

    outcome_t    pending_outcomes [$];
    plan_row_t   plan [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          hold_request = 0;
    bit          calm = 1'b0;

    label_filter_match_engine_core #(
        .POINT_COUNT (POINT_COUNT),
        .MAX_LABELS  (MAX_LABELS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("label_filter_match_engine_core_test NOT OK");
            $finish;
        end
    end

    // list membership in the predicted store
    function automatic bit list_has(int pt, logic [31:0] value);
        bit found;
        found = 1'b0;
        for (int i = 0; i < point_len[pt]; i++)
            if (point_labels[pt][i] == value)
                found = 1'b1;
        return found;
    endfunction

    // apply one command to the predicted store and return its result
    function automatic outcome_t predict_outcome(command_t c);
        outcome_t    res;
        int          n;
        bit          hit;
        logic [31:0] tmp;
        int          len_tmp;
        res = RES_CLEAN;
        if (int'(c.pa) < POINT_COUNT)
        begin
            case (c.cmd)
                CMD_CLEAR:
                    point_len[c.pa] = 0;
                CMD_APPEND:
                    if (point_len[c.pa] >= MAX_LABELS)
                        res.status = 1'b1;
                    else
                    begin
                        point_labels[c.pa][point_len[c.pa]] = c.lbl;
                        point_len[c.pa]++;
                    end
                CMD_SWAP:
                    if (int'(c.pb) < POINT_COUNT && c.pb != c.pa)
                    begin
                        for (int i = 0; i < MAX_LABELS; i++)
                        begin
                            tmp = point_labels[c.pa][i];
                            point_labels[c.pa][i] = point_labels[c.pb][i];
                            point_labels[c.pb][i] = tmp;
                        end
                        len_tmp = point_len[c.pa];
                        point_len[c.pa] = point_len[c.pb];
                        point_len[c.pb] = len_tmp;
                    end
                default:
                begin
                    n = (int'(c.qcount) > QC_LIMIT) ? QC_LIMIT : int'(c.qcount);
                    hit = 1'b0;
                    for (int i = 0; i < n; i++)
                        if (list_has(c.pa, c.ql[i]))
                            hit = 1'b1;
                    // universal label fallback, build queries also look at the query side
                    if (!hit && univ_on)
                    begin
                        if (list_has(c.pa, univ_val))
                            hit = 1'b1;
                        else if (!c.search)
                            for (int i = 0; i < n; i++)
                                if (c.ql[i] == univ_val)
                                    hit = 1'b1;
                    end
                    res.matched = hit;
                end
            endcase
        end
        return res;
    endfunction

    // commonly reused label values, so lists and queries collide often
    function automatic logic [31:0] pool_label(int k);
        case (k)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h5555_5555;
            6:       return 32'hAAAA_AAAA;
            7:       return 32'h0000_0010;
            8:       return 32'h0001_0000;
            9:       return 32'h1234_5678;
            10:      return 32'h0BAD_F00D;
            11:      return 32'h0000_00FF;
            12:      return 32'hFF00_0000;
            13:      return 32'h0F0F_0F0F;
            14:      return 32'hC001_0003;
            default: return 32'h0000_0042;
        endcase
    endfunction

    function automatic logic [31:0] pick_label();
        if ($urandom_range(0, 9) < 7)
            return pool_label($urandom_range(0, 15));
        return $urandom;
    endfunction

    // mostly a handful of points so lists fill up, sometimes anywhere
    function automatic logic [9:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 10'($urandom_range(0, 7));
        if (r < 85)
            return 10'($urandom_range(1016, 1023));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic command_t random_command();
        command_t c;
        int       r;
        r = $urandom_range(0, 99);
        c.cmd    = (r < 10) ? CMD_CLEAR : (r < 45) ? CMD_APPEND : (r < 60) ? CMD_SWAP : CMD_QUERY;
        c.pa     = pick_point();
        c.pb     = ($urandom_range(0, 9) == 0) ? c.pa : pick_point();
        c.lbl    = pick_label();
        c.qcount = 3'($urandom_range(0, 7));
        for (int i = 0; i < 4; i++)
            c.ql[i] = pick_label();
        c.search = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic command_t mk(cmd_t op, int pa, int pb, logic [31:0] lbl, int qc,
                                    logic [31:0] q0, logic [31:0] q1, logic [31:0] q2,
                                    logic [31:0] q3, bit srch);
        command_t c;
        c.cmd    = op;
        c.pa     = 10'(pa);
        c.pb     = 10'(pb);
        c.lbl    = lbl;
        c.qcount = 3'(qc);
        c.ql     = {q3, q2, q1, q0};
        c.search = srch;
        return c;
    endfunction

    // append one row to the directed table
    task automatic add_row(command_t c, bit known, outcome_t want);
        plan_row_t row;
        row.c     = c;
        row.known = known;
        row.want  = want;
        plan.insert(plan.size(), row);
    endtask

    // offer one command and record its expected result once accepted
    task automatic offer_command(command_t c, bit known, outcome_t want);
        outcome_t pred;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, c.ql, c.qcount, c.lbl, c.pb, c.pa};
        s_axis_tuser  = {c.search, c.cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = predict_outcome(c);
        pending_outcomes.insert(pending_outcomes.size(), known ? want : pred);
    endtask

    task automatic sender_gap(int n);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_UNIVERSAL_ENABLE)
            univ_on = value[0];
        else
            univ_val = value;
    endtask

    // result side readiness: random stalls, plus one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (hold_request - 1) @(negedge clk);
                hold_request = 0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        outcome_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                due = pending_outcomes.pop_front();
                if (m_axis_tdata[0] !== due.matched)
                begin
                    $error("matched: expected %0d, actual %0d", due.matched, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[1] !== due.status)
                begin
                    $error("status: expected %0d, actual %0d", due.status, m_axis_tdata[1]);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] uval;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_UNIVERSAL_ENABLE;
        cfg_wdata     = '0;
        univ_on       = 1'b0;
        univ_val      = '0;
        for (int p = 0; p < POINT_COUNT; p++)
            point_len[p] = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, reset configuration (no universal label)
        add_row(mk(CMD_QUERY, 0, 1023, 32'h0, 4, 32'h0, 32'h0, 32'h0, 32'h0, 0),
                1'b1, RES_CLEAN);
        add_row(mk(CMD_APPEND, 0, 0, 32'h0, 0, 32'h0, 32'h0, 32'h0, 32'h0, 0),
                1'b1, RES_CLEAN);
        add_row(mk(CMD_APPEND, 0, 1023, 32'hFFFF_FFFF, 7, '1, '1, '1, '1, 1),
                1'b1, RES_CLEAN);
        add_row(mk(CMD_QUERY, 0, 0, 32'h0, 1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1),
                1'b0, RES_CLEAN);
        add_row(mk(CMD_QUERY, 0, 0, 32'h0, 0, '1, '1, '1, '1, 0), 1'b0, RES_CLEAN);
        // query count above the label fields saturates to four
        add_row(mk(CMD_QUERY, 0, 0, 32'h0, 7, 32'h1234_5678, 32'h1, 32'h2, 32'h0, 0),
                1'b0, RES_CLEAN);
        // fill point 1023 to capacity
        add_row(mk(CMD_APPEND, 1023, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'h5555_5555, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        // append to a full list is dropped
        add_row(mk(CMD_APPEND, 1023, 0, 32'h0BAD_F00D, 0, 0, 0, 0, 0, 0),
                1'b1, RES_DROPPED);
        add_row(mk(CMD_QUERY, 1023, 0, 32'h0, 4, 32'h1111_1111, 32'h2222_2222,
                   32'h3333_3333, 32'hAAAA_AAAA, 1), 1'b0, RES_CLEAN);
        add_row(mk(CMD_SWAP, 0, 1023, 32'h0, 0, 0, 0, 0, 0, 0), 1'b1, RES_CLEAN);
        add_row(mk(CMD_QUERY, 0, 0, 32'h0, 4, 32'h3, 32'h4, 32'h6, 32'h5555_5555, 0),
                1'b0, RES_CLEAN);
        // swap of a point with itself
        add_row(mk(CMD_SWAP, 5, 5, 32'h0, 0, 0, 0, 0, 0, 0), 1'b1, RES_CLEAN);
        add_row(mk(CMD_SWAP, 1023, 512, 32'h0, 0, 0, 0, 0, 0, 0), 1'b0, RES_CLEAN);
        add_row(mk(CMD_QUERY, 512, 0, 32'h0, 2, 32'h9, 32'hFFFF_FFFF, 0, 0, 1),
                1'b0, RES_CLEAN);
        add_row(mk(CMD_CLEAR, 0, 1023, '1, 7, '1, '1, '1, '1, 1), 1'b1, RES_CLEAN);
        add_row(mk(CMD_QUERY, 0, 0, 32'h0, 4, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0, 32'hFFFF_FFFF, 0), 1'b1, RES_CLEAN);
        add_row(mk(CMD_APPEND, 1023, 0, 32'hC001_0003, 0, 0, 0, 0, 0, 0),
                1'b0, RES_CLEAN);
        foreach (plan[i])
            offer_command(plan[i].c, plan[i].known, plan[i].want);
        drain();

        // random phases across universal label settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       uval = 32'h0000_0000;
                1:       uval = 32'hFFFF_FFFF;
                default: uval = pool_label($urandom_range(0, 15));
            endcase
            write_reg(REG_UNIVERSAL_ENABLE, (ph == 3) ? 32'd0 : 32'd1);
            write_reg(REG_UNIVERSAL_VALUE, uval);
            calm = (ph == PHASES - 1);
            // long result hold while commands keep coming
            if (ph == 0)
                hold_request = HOLD_CYCLES;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    drain();
                else if (!calm && $urandom_range(0, 9) == 0)
                    sender_gap($urandom_range(1, 17));
                offer_command(random_command(), 1'b0, RES_CLEAN);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("label_filter_match_engine_core_test OK");
        else
            $display("label_filter_match_engine_core_test NOT OK");
        $finish;
    end

endmodule
